// ===== sv/pcp_pkg.sv =====
// Shared types and constants for the convex polyhedron point test.
// Used by pcp_plane_mem, pcp_mac and point_in_convex_polyhedron.
package pcp_pkg;

    localparam int DEF_MAX_FACES = 64;
    localparam int FACE_IDX_W    = 6;
    localparam int FACE_CNT_W    = 7;
    localparam int ACC_W         = 67;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    typedef struct packed {
        logic                  command;
        logic [FACE_IDX_W-1:0] face_index;
        logic signed [31:0]    plane_a;
        logic signed [31:0]    plane_b;
        logic signed [31:0]    plane_c;
        logic signed [63:0]    plane_d;
        logic signed [31:0]    point_x;
        logic signed [31:0]    point_y;
        logic signed [31:0]    point_z;
    } t_in_word;

    typedef struct packed {
        logic                  inside_res;
        logic [FACE_IDX_W-1:0] first_outside_face;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [63:0] d;
    } t_plane;

    typedef struct packed {
        logic load_offset;
        logic mul_en;
        logic acc_en;
    } t_mac_ctl;

endpackage

// ===== sv/pcp_plane_mem.sv =====
// Face plane table: one write port, one registered read port.
// Depends on pcp_pkg.
module pcp_plane_mem #(
    parameter int MAX_FACES = pcp_pkg::DEF_MAX_FACES,
    localparam int IW = $clog2(MAX_FACES)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_addr,
    input  pcp_pkg::t_plane  i_wr_data,
    input  logic [IW-1:0]    i_rd_addr,
    output pcp_pkg::t_plane  o_rd_data
);
    import pcp_pkg::*;

    t_plane r_mem [MAX_FACES];
    t_plane r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/pcp_mac.sv =====
// Shared 32x32 signed multiplier with a registered product and a 67-bit
// accumulator; flags a strictly positive sum. Depends on pcp_pkg.
module pcp_mac (
    input  logic               i_clk,
    input  pcp_pkg::t_mac_ctl  i_ctl,
    input  logic signed [31:0] i_op_a,
    input  logic signed [31:0] i_op_b,
    input  logic signed [63:0] i_offset,
    output logic               o_pos
);
    import pcp_pkg::*;

    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        if (i_ctl.load_offset) begin
            r_acc <= {{(ACC_W-64){i_offset[63]}}, i_offset};
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + {{(ACC_W-64){r_prod[63]}}, r_prod};
        end
    end

    assign o_pos = !r_acc[ACC_W-1] && (|r_acc);

endmodule

// ===== sv/point_in_convex_polyhedron.sv =====
// Point-in-convex-polyhedron test over a table of outward face planes.
// A test evaluates A*x+B*y+C*z+D face by face from face 0, over at most
// min(face_count, MAX_FACES) faces, and stops at the first strictly positive
// face; its result waits while the previous result word is held by output stall.
// Each face passes S_FETCH, S_MUL, S_ACC and S_CHECK, with the one shared 32x32
// multiplier forming the three products of a face in turn after the registered
// read of the plane table. Input stall is high for the whole test.
// The user must write face_count only while the block is idle; the block
// itself does not enforce it. Depends on pcp_pkg, pcp_plane_mem and pcp_mac.
module point_in_convex_polyhedron #(
    parameter int MAX_FACES = pcp_pkg::DEF_MAX_FACES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pcp_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pcp_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pcp_pkg::FACE_CNT_W-1:0]     i_cfg_data
);
    import pcp_pkg::*;

    localparam int IW = $clog2(MAX_FACES);
    localparam int FW = $clog2(MAX_FACES + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_MUL   = 6'b000100,
        S_ACC   = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [FACE_CNT_W-1:0] r_face_count;
    logic [FW-1:0]         r_face, n_face;
    logic [FW-1:0]         r_limit, n_limit;
    logic [1:0]            r_step, n_step;
    logic signed [31:0]    r_px, r_py, r_pz;
    t_out_word             r_res, n_res;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic       in_acc;
    logic       wr_en;
    logic       out_free;
    logic       last_face;
    logic [FW-1:0] face_inc;
    t_plane     rd_plane;
    t_plane     wr_plane;
    t_mac_ctl   mac_ctl;
    logic signed [31:0] op_a, op_b;
    logic       mac_pos;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign wr_en    = in_acc && (i_in_word.command == CMD_WRITE)
                      && ({26'd0, i_in_word.face_index} < 32'(MAX_FACES));
    assign face_inc  = r_face + 1'b1;
    assign last_face = (face_inc == r_limit);

    assign wr_plane.a = i_in_word.plane_a;
    assign wr_plane.b = i_in_word.plane_b;
    assign wr_plane.c = i_in_word.plane_c;
    assign wr_plane.d = i_in_word.plane_d;

    pcp_plane_mem #(
        .MAX_FACES (MAX_FACES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IW'(i_in_word.face_index)),
        .i_wr_data (wr_plane),
        .i_rd_addr (r_face[IW-1:0]),
        .o_rd_data (rd_plane)
    );

    always_comb begin
        case (r_step)
            2'd0:    begin op_a = rd_plane.a; op_b = r_px; end
            2'd1:    begin op_a = rd_plane.b; op_b = r_py; end
            default: begin op_a = rd_plane.c; op_b = r_pz; end
        endcase
    end

    assign mac_ctl.load_offset = (r_state == S_MUL) && (r_step == 2'd0);
    assign mac_ctl.mul_en      = (r_state == S_MUL);
    assign mac_ctl.acc_en      = ((r_state == S_MUL) && (r_step != 2'd0))
                                 || (r_state == S_ACC);

    pcp_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_op_a   (op_a),
        .i_op_b   (op_b),
        .i_offset (rd_plane.d),
        .o_pos    (mac_pos)
    );

    always_comb begin
        n_state = r_state;
        n_face  = r_face;
        n_limit = r_limit;
        n_step  = r_step;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_word.command == CMD_TEST)) begin
                    n_face = '0;
                    n_step = 2'd0;
                    if ({25'd0, r_face_count} > 32'(MAX_FACES)) begin
                        n_limit = FW'(MAX_FACES);
                    end else begin
                        n_limit = FW'(r_face_count);
                    end
                    if (r_face_count == '0) begin
                        n_res.inside_res         = 1'b1;
                        n_res.first_outside_face = '0;
                        n_state                  = S_DONE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_step  = 2'd0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd2) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (mac_pos) begin
                    n_res.inside_res         = 1'b0;
                    n_res.first_outside_face = FACE_IDX_W'(r_face);
                    n_state                  = S_DONE;
                end else if (last_face) begin
                    n_res.inside_res         = 1'b1;
                    n_res.first_outside_face = '0;
                    n_state                  = S_DONE;
                end else begin
                    n_face  = face_inc;
                    n_state = S_FETCH;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_face_count <= '0;
            r_face       <= '0;
            r_limit      <= '0;
            r_step       <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_face  <= n_face;
            r_limit <= n_limit;
            r_step  <= n_step;
            if (i_cfg_valid && o_cfg_ready) begin
                r_face_count <= i_cfg_data;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (in_acc && (i_in_word.command == CMD_TEST)) begin
            r_px <= i_in_word.point_x;
            r_py <= i_in_word.point_y;
            r_pz <= i_in_word.point_z;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_word <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_test_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_word.command == CMD_TEST)) |=> o_in_stall)
        else $error("input not stalled after a test word");

    a_face_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_face < r_limit))
        else $error("face counter past limit");

    a_inside_face_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.inside_res) |-> (o_out_word.first_outside_face == '0))
        else $error("inside result with nonzero face");

endmodule

// ===== dv/tb.sv =====
// Testbench for point_in_convex_polyhedron: plane table writes and point tests,
// checked against an in-bench half-space predictor with a wide exact sum.
// Depends on pcp_pkg and the point_in_convex_polyhedron RTL.
module tb;
    import pcp_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_word              in_word = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_word             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [FACE_CNT_W-1:0] cfg_data = '0;

    // predictor copy of the plane table and face count
    logic signed [31:0]    nrm_a [DEF_MAX_FACES];
    logic signed [31:0]    nrm_b [DEF_MAX_FACES];
    logic signed [31:0]    nrm_c [DEF_MAX_FACES];
    logic signed [63:0]    offs  [DEF_MAX_FACES];
    logic [FACE_CNT_W-1:0] face_cnt_m = '0;

    t_out_word verdict_q [$];
    t_out_word exp_word;
    int        err_count = 0;
    int        n_tests = 0;
    int        n_inside = 0;
    int        n_writes = 0;
    int        n_settings = 0;
    int        stall_left = 0;
    bit        no_idle = 1'b0;

    always #6 clk = ~clk;

    point_in_convex_polyhedron DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    function automatic t_out_word classify_point(input logic signed [31:0] px, py, pz);
        t_out_word                r;
        logic signed [ACC_W-1:0] side_val;
        int                       n;
        int                       i;
        r.inside_res         = 1'b1;
        r.first_outside_face = '0;
        n = (face_cnt_m > DEF_MAX_FACES) ? DEF_MAX_FACES : face_cnt_m;
        for (i = 0; i < n; i++) begin
            side_val = nrm_a[i] * px + nrm_b[i] * py + nrm_c[i] * pz + offs[i];
            if (side_val > 0) begin
                r.inside_res         = 1'b0;
                r.first_outside_face = i[FACE_IDX_W-1:0];
                return r;
            end
        end
        return r;
    endfunction

    function automatic void apply_word(input t_in_word w);
        t_out_word r;
        if (w.command == CMD_WRITE) begin
            nrm_a[w.face_index] = w.plane_a;
            nrm_b[w.face_index] = w.plane_b;
            nrm_c[w.face_index] = w.plane_c;
            offs[w.face_index]  = w.plane_d;
            n_writes++;
        end else begin
            r = classify_point(w.point_x, w.point_y, w.point_z);
            verdict_q.push_back(r);
            n_tests++;
            if (r.inside_res) n_inside++;
        end
    endfunction

    function automatic logic signed [31:0] rand_scaled(input int lo);
        return $signed($urandom) >>> $urandom_range(lo, 31);
    endfunction

    // negative offset so that points near the origin tend to be inside
    function automatic logic signed [63:0] rand_offset();
        logic [62:0] mag;
        mag = 63'({$urandom, $urandom});
        return -($signed({1'b0, mag}) >>> $urandom_range(0, 30));
    endfunction

    function automatic t_in_word plane_word(input logic [FACE_IDX_W-1:0] slot,
                                            input logic signed [31:0] a, b, c,
                                            input logic signed [63:0] d);
        t_in_word w;
        w.command    = CMD_WRITE;
        w.face_index = slot;
        w.plane_a    = a;
        w.plane_b    = b;
        w.plane_c    = c;
        w.plane_d    = d;
        w.point_x    = $urandom;
        w.point_y    = $urandom;
        w.point_z    = $urandom;
        return w;
    endfunction

    function automatic t_in_word point_word(input logic signed [31:0] x, y, z);
        t_in_word w;
        w.command    = CMD_TEST;
        w.face_index = FACE_IDX_W'($urandom_range(0, DEF_MAX_FACES - 1));
        w.plane_a    = $urandom;
        w.plane_b    = $urandom;
        w.plane_c    = $urandom;
        w.plane_d    = {$urandom, $urandom};
        w.point_x    = x;
        w.point_y    = y;
        w.point_z    = z;
        return w;
    endfunction

    // valid stays high across back-to-back words; it drops before a gap and in wait_idle
    task automatic send_word(input t_in_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        apply_word(w);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_face_count(input logic [FACE_CNT_W-1:0] cnt);
        cfg_valid <= 1'b1;
        cfg_data  <= cnt;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid  <= 1'b0;
        face_cnt_m  = cnt;
        n_settings++;
    endtask

    // result side: a random per-word stall (none when no_idle is set), counted while a word is offered
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left  = 0;
        end else if (out_valid) begin
            if (!out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected result word: inside_res %0d first_outside_face %0d",
                           out_word.inside_res, out_word.first_outside_face);
                    err_count++;
                end else begin
                    exp_word = verdict_q.pop_front();
                    if (out_word.inside_res !== exp_word.inside_res) begin
                        $error("inside_res: expected %0d, got %0d",
                               exp_word.inside_res, out_word.inside_res);
                        err_count++;
                    end
                    if (out_word.first_outside_face !== exp_word.first_outside_face) begin
                        $error("first_outside_face: expected %0d, got %0d",
                               exp_word.first_outside_face, out_word.first_outside_face);
                        err_count++;
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 7);
                out_stall <= (stall_left != 0);
            end else begin
                stall_left--;
                if (stall_left == 0) out_stall <= 1'b0;
            end
        end
    end

    task automatic test_empty_table();
        set_face_count('0);
        send_word(point_word(32'sh8000_0000, 32'sh7FFF_FFFF, '0));
        send_word(point_word('0, '0, '0));
        wait_idle();
    endtask

    // axis-aligned faces x<=5, y<=5, z>=-5 plus one extreme-valued face
    task automatic test_axis_faces();
        logic signed [63:0] five;
        five = 64'sd5 <<< 32;
        send_word(plane_word(6'd0, 32'sh0001_0000, '0, '0, -five));
        send_word(plane_word(6'd1, '0, 32'sh0001_0000, '0, -five));
        send_word(plane_word(6'd2, '0, '0, 32'shFFFF_0000, -five));
        send_word(plane_word(6'd3, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                             64'sh8000_0000_0000_0000));
        wait_idle();
        set_face_count(7'd4);
        send_word(point_word('0, '0, '0));
        send_word(point_word(32'sh0005_0000, '0, '0));       // on the face: inside
        send_word(point_word(32'sh0005_0001, '0, '0));       // one lsb past it
        send_word(point_word('0, 32'sh0006_0000, '0));
        send_word(point_word('0, '0, 32'shFFFA_0000));
        send_word(point_word(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
        wait_idle();
        set_face_count(7'd1);
        send_word(point_word('0, 32'sh0006_0000, '0));
        wait_idle();
    endtask

    // sums that leave the 64-bit range in both directions
    task automatic test_wide_sum();
        set_face_count(7'd4);
        send_word(plane_word(6'd3, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                             64'sh7FFF_FFFF_FFFF_FFFF));
        send_word(point_word(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_word(plane_word(6'd3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                             64'shC000_0000_0000_0000));
        send_word(point_word(32'sh8000_0000, 32'sh8000_0000, 32'shFFFB_0000));
        wait_idle();
    endtask

    task automatic fill_table();
        int k;
        for (k = 0; k < DEF_MAX_FACES; k++)
            send_word(plane_word(k[FACE_IDX_W-1:0], rand_scaled(0), rand_scaled(0),
                                 rand_scaled(0), rand_offset()));
    endtask

    // plane through a point, nudged by -1/0/+1 lsb, then a test of that point
    task automatic send_boundary(input int eff);
        logic signed [31:0]      a, b, c, x, y, z;
        logic signed [ACC_W-1:0] s;
        logic signed [63:0]      d;
        int                      delta;
        int                      k;
        a = rand_scaled(2);
        b = rand_scaled(2);
        c = rand_scaled(2);
        x = rand_scaled(0);
        y = rand_scaled(0);
        z = rand_scaled(0);
        s = a * x + b * y + c * z;
        delta = int'($urandom_range(0, 2)) - 1;
        d = 64'(-s + delta);
        k = (eff == 0 || $urandom_range(0, 1)) ? 0 : $urandom_range(0, eff - 1);
        send_word(plane_word(k[FACE_IDX_W-1:0], a, b, c, d));
        send_word(point_word(x, y, z));
    endtask

    task automatic test_random_mix(input int n_items, input logic [FACE_CNT_W-1:0] cnt,
                                   input bit refill, input bit gapless);
        int j;
        int r;
        int eff;
        wait_idle();
        set_face_count(cnt);
        no_idle = gapless;
        eff = (cnt > DEF_MAX_FACES) ? DEF_MAX_FACES : cnt;
        if (refill) fill_table();
        for (j = 0; j < n_items; j++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_word(point_word(rand_scaled(0), rand_scaled(0), rand_scaled(0)));
            else if (r < 65)
                send_word(point_word($urandom, $urandom, $urandom));
            else if (r < 80)
                send_word(plane_word(FACE_IDX_W'($urandom_range(0, DEF_MAX_FACES - 1)),
                                     rand_scaled(0), rand_scaled(0), rand_scaled(0),
                                     rand_offset()));
            else if (r < 85)
                send_word(plane_word(FACE_IDX_W'($urandom_range(0, DEF_MAX_FACES - 1)),
                                     $urandom, $urandom, $urandom,
                                     {$urandom, $urandom}));
            else
                send_boundary(eff);
        end
        wait_idle();
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_axis_faces();
        test_wide_sum();
        test_random_mix(200, 7'd64, 1'b1, 1'b0);
        test_random_mix(180, 7'd127, 1'b1, 1'b0);
        test_random_mix(150, 7'($urandom_range(1, 63)), 1'b0, 1'b1);
        test_random_mix(120, 7'd1, 1'b0, 1'b0);
        test_random_mix(100, 7'd0, 1'b0, 1'b0);
        test_random_mix(180, 7'($urandom_range(65, 126)), 1'b1, 1'b0);
        test_random_mix(150, 7'($urandom_range(2, 64)), 1'b1, 1'b1);
        wait_idle();
        repeat (400) @(posedge clk);
        $display("covered %0d point tests (%0d inside, %0d outside) and %0d plane writes",
                 n_tests, n_inside, n_tests - n_inside, n_writes);
        $display("across %0d face count settings, %0d mismatches", n_settings, err_count);
        if (err_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("timeout with %0d results outstanding", verdict_q.size());
        $display("tb failed");
        $finish;
    end

endmodule
